[src/spr_pkg.sv]
// shared types, constants and lookup functions for the sensor payload record decoder
// no dependencies
`timescale 1ns / 1ps

package spr_pkg;

    localparam int unsigned PAYLOAD_MAX = 9;
    localparam int unsigned IDX_W       = $clog2(PAYLOAD_MAX);

    // byte positions inside a record
    localparam logic [3:0] POS_CHANNEL = 4'd0;
    localparam logic [3:0] POS_TYPE    = 4'd1;
    localparam logic [3:0] POS_PAYLOAD = 4'd2;

    // type bytes on the wire
    localparam logic [7:0] TYPE_DIN      = 8'd0;
    localparam logic [7:0] TYPE_DOUT     = 8'd1;
    localparam logic [7:0] TYPE_AIN      = 8'd2;
    localparam logic [7:0] TYPE_AOUT     = 8'd3;
    localparam logic [7:0] TYPE_LUX      = 8'd101;
    localparam logic [7:0] TYPE_PRESENCE = 8'd102;
    localparam logic [7:0] TYPE_TEMP     = 8'd103;
    localparam logic [7:0] TYPE_HUMIDITY = 8'd104;
    localparam logic [7:0] TYPE_ACCEL    = 8'd113;
    localparam logic [7:0] TYPE_BARO     = 8'd115;
    localparam logic [7:0] TYPE_TIME     = 8'd133;
    localparam logic [7:0] TYPE_GYRO     = 8'd134;
    localparam logic [7:0] TYPE_GPS      = 8'd136;

    // dense kind codes
    localparam logic [3:0] KIND_DIN      = 4'd0;
    localparam logic [3:0] KIND_DOUT     = 4'd1;
    localparam logic [3:0] KIND_AIN      = 4'd2;
    localparam logic [3:0] KIND_AOUT     = 4'd3;
    localparam logic [3:0] KIND_LUX      = 4'd4;
    localparam logic [3:0] KIND_PRESENCE = 4'd5;
    localparam logic [3:0] KIND_TEMP     = 4'd6;
    localparam logic [3:0] KIND_HUMIDITY = 4'd7;
    localparam logic [3:0] KIND_ACCEL    = 4'd8;
    localparam logic [3:0] KIND_BARO     = 4'd9;
    localparam logic [3:0] KIND_TIME     = 4'd10;
    localparam logic [3:0] KIND_GYRO     = 4'd11;
    localparam logic [3:0] KIND_GPS      = 4'd12;

    typedef logic [PAYLOAD_MAX-1:0][7:0] t_payload;

    typedef struct packed {
        logic       known;
        logic [3:0] kind;
    } t_type_lu;

    // one classified entry handed from front to back
    typedef struct packed {
        logic       rec_valid;
        logic [7:0] channel;
        logic [3:0] kind;
        t_payload   payload;
        logic       buf_end;
        logic       buf_ok;
    } t_rec;

    function automatic t_type_lu type_to_kind(input logic [7:0] t);
        t_type_lu r;
        r.known = 1'b1;
        r.kind  = KIND_DIN;
        case (t)
            TYPE_DIN:      r.kind = KIND_DIN;
            TYPE_DOUT:     r.kind = KIND_DOUT;
            TYPE_AIN:      r.kind = KIND_AIN;
            TYPE_AOUT:     r.kind = KIND_AOUT;
            TYPE_LUX:      r.kind = KIND_LUX;
            TYPE_PRESENCE: r.kind = KIND_PRESENCE;
            TYPE_TEMP:     r.kind = KIND_TEMP;
            TYPE_HUMIDITY: r.kind = KIND_HUMIDITY;
            TYPE_ACCEL:    r.kind = KIND_ACCEL;
            TYPE_BARO:     r.kind = KIND_BARO;
            TYPE_TIME:     r.kind = KIND_TIME;
            TYPE_GYRO:     r.kind = KIND_GYRO;
            TYPE_GPS:      r.kind = KIND_GPS;
            default:       r.known = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] kind_size(input logic [3:0] k);
        logic [3:0] s;
        case (k)
            KIND_AIN, KIND_AOUT, KIND_LUX, KIND_TEMP, KIND_BARO: s = 4'd2;
            KIND_ACCEL, KIND_GYRO: s = 4'd6;
            KIND_TIME:             s = 4'd4;
            KIND_GPS:              s = 4'd9;
            default:               s = 4'd1;
        endcase
        return s;
    endfunction

endpackage

[src/spr_front.sv]
// front end: takes bytes, tracks record position, collects payload bytes
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_front
    import spr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_rec_push,
    output t_rec       o_rec
);

    logic [3:0] r_pos,  n_pos;
    logic [7:0] r_chan, n_chan;
    logic [3:0] r_kind, n_kind;
    logic       r_err,  n_err;
    t_payload   r_payload, n_payload;

    t_type_lu   type_lu;
    logic [3:0] idx;
    logic [3:0] idx_next;
    logic       complete;

    always_comb begin
        n_pos     = r_pos;
        n_chan    = r_chan;
        n_kind    = r_kind;
        n_err     = r_err;
        n_payload = r_payload;
        complete  = 1'b0;
        type_lu   = type_to_kind(i_data_byte);
        idx       = r_pos - POS_PAYLOAD;
        idx_next  = idx + 4'd1;
        if (i_accept) begin
            if (!r_err) begin
                case (r_pos)
                    POS_CHANNEL: begin
                        n_chan = i_data_byte;
                        n_pos  = POS_TYPE;
                    end
                    POS_TYPE: begin
                        if (!type_lu.known) begin
                            n_err = 1'b1;
                            n_pos = POS_CHANNEL;
                        end else begin
                            n_kind = type_lu.kind;
                            n_pos  = POS_PAYLOAD;
                        end
                    end
                    default: begin
                        if (idx < 4'(PAYLOAD_MAX)) begin
                            n_payload[idx[IDX_W-1:0]] = i_data_byte;
                        end
                        if (idx_next >= kind_size(r_kind)) begin
                            complete = 1'b1;
                            n_pos    = POS_CHANNEL;
                        end else begin
                            n_pos = r_pos + 4'd1;
                        end
                    end
                endcase
            end
            // buffer end always restarts parsing
            if (i_last_byte) begin
                n_pos = POS_CHANNEL;
                n_err = 1'b0;
            end
        end
    end

    always_comb begin
        o_rec_push      = i_accept && (complete || i_last_byte);
        o_rec.rec_valid = complete;
        o_rec.channel   = r_chan;
        o_rec.kind      = r_kind;
        o_rec.payload   = n_payload;
        o_rec.buf_end   = i_last_byte;
        o_rec.buf_ok    = i_last_byte && complete;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_CHANNEL;
            r_chan <= '0;
            r_kind <= KIND_DIN;
            r_err  <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_chan <= n_chan;
            r_kind <= n_kind;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_payload <= n_payload;
    end

endmodule

[src/spr_queue.sv]
// short queue of classified records between front and back
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_queue
    import spr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_avail,
    output t_rec o_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("record queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("record queue read while empty");

endmodule

[src/spr_back.sv]
// back end: decodes queued records into values and holds the result register
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_back
    import spr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  t_rec               i_rec,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output logic               o_record_valid,
    output logic [7:0]         o_channel,
    output logic [3:0]         o_kind,
    output logic signed [32:0] o_value_x,
    output logic signed [23:0] o_value_y,
    output logic signed [23:0] o_value_z,
    output logic               o_buffer_end,
    output logic               o_buffer_ok
);

    logic        r_out_valid;
    logic        r_rec_valid;
    logic [7:0]  r_channel;
    logic [3:0]  r_kind;
    logic [32:0] r_x;
    logic [23:0] r_y;
    logic [23:0] r_z;
    logic        r_end;
    logic        r_ok;

    logic [32:0] n_x;
    logic [23:0] n_y;
    logic [23:0] n_z;
    logic        load;
    t_payload    p;

    assign p = i_rec.payload;

    always_comb begin
        n_x = '0;
        n_y = '0;
        n_z = '0;
        if (i_rec.rec_valid) begin
            case (i_rec.kind)
                KIND_DIN, KIND_DOUT, KIND_PRESENCE, KIND_HUMIDITY: begin
                    n_x = {25'd0, p[0]};
                end
                KIND_AIN, KIND_AOUT, KIND_TEMP: begin
                    n_x = {{17{p[0][7]}}, p[0], p[1]};
                end
                KIND_LUX, KIND_BARO: begin
                    n_x = {17'd0, p[0], p[1]};
                end
                KIND_ACCEL, KIND_GYRO: begin
                    n_x = {{17{p[0][7]}}, p[0], p[1]};
                    n_y = {{8{p[2][7]}}, p[2], p[3]};
                    n_z = {{8{p[4][7]}}, p[4], p[5]};
                end
                KIND_TIME: begin
                    n_x = {1'b0, p[0], p[1], p[2], p[3]};
                end
                KIND_GPS: begin
                    n_x = {{9{p[0][7]}}, p[0], p[1], p[2]};
                    n_y = {p[3], p[4], p[5]};
                    n_z = {p[6], p[7], p[8]};
                end
                default: begin
                    n_x = '0;
                end
            endcase
        end
    end

    // result register refills when empty or when its transfer completes
    assign load   = i_avail && (!r_out_valid || i_pop);
    assign o_take = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec_valid <= i_rec.rec_valid;
            r_channel   <= i_rec.rec_valid ? i_rec.channel : 8'd0;
            r_kind      <= i_rec.rec_valid ? i_rec.kind : KIND_DIN;
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
            r_end       <= i_rec.buf_end;
            r_ok        <= i_rec.buf_ok;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_record_valid = r_rec_valid;
    assign o_channel      = r_channel;
    assign o_kind         = r_kind;
    assign o_value_x      = $signed(r_x);
    assign o_value_y      = $signed(r_y);
    assign o_value_z      = $signed(r_z);
    assign o_buffer_end   = r_end;
    assign o_buffer_ok    = r_ok;

    a_ok_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ok) |-> (r_end && r_rec_valid))
        else $error("clean status without a closing record");

endmodule

[src/sensor_payload_record_decoder.sv]
// top level: byte-stream record decoder, front end, record queue and back end
// depends on spr_pkg, spr_front, spr_queue, spr_back
`timescale 1ns / 1ps

// throughput: one byte per cycle, full rises only when QUEUE_DEPTH records wait behind
//   a result that is not popped
// path: the record with the final byte enters the queue at the edge that takes that byte
//   and moves into the result register once that register is empty or is being popped
// reset: synchronous active low; clears record position, error flag, queue pointers
//   and the result valid flag, so the block expects a channel byte

module sensor_payload_record_decoder
    import spr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               empty,
    input  logic               pop,
    output logic               o_record_valid,
    output logic [7:0]         o_channel,
    output logic [3:0]         o_kind,
    output logic signed [32:0] o_value_x,
    output logic signed [23:0] o_value_y,
    output logic signed [23:0] o_value_z,
    output logic               o_buffer_end,
    output logic               o_buffer_ok
);

    logic accept;
    logic rec_push;
    t_rec front_rec;
    logic q_full;
    logic q_avail;
    t_rec q_rec;
    logic q_take;

    assign full   = q_full;
    assign accept = push && !q_full;

    spr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_rec_push  (rec_push),
        .o_rec       (front_rec)
    );

    spr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_take),
        .o_avail (q_avail),
        .o_rec   (q_rec)
    );

    spr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_avail),
        .i_rec          (q_rec),
        .o_take         (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_record_valid (o_record_valid),
        .o_channel      (o_channel),
        .o_kind         (o_kind),
        .o_value_x      (o_value_x),
        .o_value_y      (o_value_y),
        .o_value_z      (o_value_z),
        .o_buffer_end   (o_buffer_end),
        .o_buffer_ok    (o_buffer_ok)
    );

endmodule

[tb/tb.sv]
// self-checking bench for sensor_payload_record_decoder: random buffers of records,
// truncations, unknown types and noise, checked against a byte-level decoder model
// depends on spr_pkg and sensor_payload_record_decoder
`timescale 1ns / 1ps

module tb;
    import spr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1950;

    typedef struct {
        logic               record_valid;
        logic [7:0]         channel;
        logic [3:0]         kind;
        logic signed [32:0] value_x;
        logic signed [23:0] value_y;
        logic signed [23:0] value_z;
        logic               buffer_end;
        logic               buffer_ok;
    } lpp_result_t;

    // byte-level decoder model plus the queue of records it predicts
    class record_predictor;
        logic [3:0]  byte_pos;
        logic [7:0]  chan_q;
        logic [3:0]  kind_q;
        logic [7:0]  pl[9];
        bit          skip_rest;
        lpp_result_t expected_q[$];
        int          errors;

        function new();
            byte_pos  = POS_CHANNEL;
            chan_q    = '0;
            kind_q    = '0;
            skip_rest = 1'b0;
            errors    = 0;
            foreach (pl[i]) pl[i] = '0;
        endfunction

        static function bit lookup_kind(input logic [7:0] t, output logic [3:0] k);
            bit known;
            known = 1'b1;
            k = KIND_DIN;
            case (t)
                TYPE_DIN:      k = KIND_DIN;
                TYPE_DOUT:     k = KIND_DOUT;
                TYPE_AIN:      k = KIND_AIN;
                TYPE_AOUT:     k = KIND_AOUT;
                TYPE_LUX:      k = KIND_LUX;
                TYPE_PRESENCE: k = KIND_PRESENCE;
                TYPE_TEMP:     k = KIND_TEMP;
                TYPE_HUMIDITY: k = KIND_HUMIDITY;
                TYPE_ACCEL:    k = KIND_ACCEL;
                TYPE_BARO:     k = KIND_BARO;
                TYPE_TIME:     k = KIND_TIME;
                TYPE_GYRO:     k = KIND_GYRO;
                TYPE_GPS:      k = KIND_GPS;
                default:       known = 1'b0;
            endcase
            return known;
        endfunction

        static function int payload_len(input logic [3:0] k);
            case (k)
                KIND_AIN, KIND_AOUT, KIND_LUX, KIND_TEMP, KIND_BARO: return 2;
                KIND_ACCEL, KIND_GYRO: return 6;
                KIND_TIME:             return 4;
                KIND_GPS:              return 9;
                default:               return 1;
            endcase
        endfunction

        function logic signed [15:0] s16(input int i);
            return {pl[i], pl[i+1]};
        endfunction

        function logic signed [23:0] s24(input int i);
            return {pl[i], pl[i+1], pl[i+2]};
        endfunction

        function void decode_into(inout lpp_result_t r);
            r.record_valid = 1'b1;
            r.channel      = chan_q;
            r.kind         = kind_q;
            case (kind_q)
                KIND_DIN, KIND_DOUT, KIND_PRESENCE, KIND_HUMIDITY:
                    r.value_x = {25'b0, pl[0]};
                KIND_AIN, KIND_AOUT, KIND_TEMP:
                    r.value_x = s16(0);
                KIND_LUX, KIND_BARO:
                    r.value_x = {17'b0, pl[0], pl[1]};
                KIND_ACCEL, KIND_GYRO: begin
                    r.value_x = s16(0);
                    r.value_y = s16(2);
                    r.value_z = s16(4);
                end
                KIND_TIME:
                    r.value_x = {1'b0, pl[0], pl[1], pl[2], pl[3]};
                KIND_GPS: begin
                    r.value_x = s24(0);
                    r.value_y = s24(3);
                    r.value_z = s24(6);
                end
                default: ;
            endcase
        endfunction

        function void take_byte(input logic [7:0] b, input logic lst);
            lpp_result_t r;
            bit          done;
            logic [3:0]  k;
            int          idx;
            r = '{default: '0};
            done = 1'b0;
            if (!skip_rest) begin
                if (byte_pos == POS_CHANNEL) begin
                    chan_q   = b;
                    byte_pos = POS_TYPE;
                end else if (byte_pos == POS_TYPE) begin
                    if (lookup_kind(b, k)) begin
                        kind_q   = k;
                        byte_pos = POS_PAYLOAD;
                    end else begin
                        // rest of the buffer is dropped until its last byte
                        skip_rest = 1'b1;
                        byte_pos  = POS_CHANNEL;
                    end
                end else begin
                    idx = int'(byte_pos) - int'(POS_PAYLOAD);
                    if (idx < 9) pl[idx] = b;
                    if (idx + 1 >= payload_len(kind_q)) begin
                        done     = 1'b1;
                        byte_pos = POS_CHANNEL;
                    end else begin
                        byte_pos = byte_pos + 4'd1;
                    end
                end
            end
            if (!done && !lst) return;
            if (done) decode_into(r);
            if (lst) begin
                r.buffer_end = 1'b1;
                r.buffer_ok  = !skip_rest && byte_pos == POS_CHANNEL && done;
                byte_pos     = POS_CHANNEL;
                skip_rest    = 1'b0;
            end
            expected_q.push_back(r);
        endfunction

        function void check_record(input lpp_result_t got);
            lpp_result_t want;
            if (expected_q.size() == 0) begin
                $error("record transfer with nothing pending: channel %0d kind %0d end %0d",
                       got.channel, got.kind, got.buffer_end);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.record_valid !== want.record_valid) begin
                $error("record_valid: expected %0d, actual %0d",
                       want.record_valid, got.record_valid);
                errors++;
            end
            if (got.channel !== want.channel) begin
                $error("channel: expected %0d, actual %0d", want.channel, got.channel);
                errors++;
            end
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.value_x !== want.value_x) begin
                $error("value_x: expected %0d, actual %0d", want.value_x, got.value_x);
                errors++;
            end
            if (got.value_y !== want.value_y) begin
                $error("value_y: expected %0d, actual %0d", want.value_y, got.value_y);
                errors++;
            end
            if (got.value_z !== want.value_z) begin
                $error("value_z: expected %0d, actual %0d", want.value_z, got.value_z);
                errors++;
            end
            if (got.buffer_end !== want.buffer_end) begin
                $error("buffer_end: expected %0d, actual %0d", want.buffer_end, got.buffer_end);
                errors++;
            end
            if (got.buffer_ok !== want.buffer_ok) begin
                $error("buffer_ok: expected %0d, actual %0d", want.buffer_ok, got.buffer_ok);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_data_byte;
    logic               i_last_byte;
    logic               empty;
    logic               pop;
    logic               o_record_valid;
    logic [7:0]         o_channel;
    logic [3:0]         o_kind;
    logic signed [32:0] o_value_x;
    logic signed [23:0] o_value_y;
    logic signed [23:0] o_value_z;
    logic               o_buffer_end;
    logic               o_buffer_ok;

    record_predictor pred;
    logic [7:0]      buf_q[$];
    int              bytes_sent;
    int              results_seen;
    int              cycles;
    bit              rx_holding;
    bit              hold_done;

    logic [7:0] type_codes[13] = '{TYPE_DIN, TYPE_DOUT, TYPE_AIN, TYPE_AOUT, TYPE_LUX,
                                   TYPE_PRESENCE, TYPE_TEMP, TYPE_HUMIDITY, TYPE_ACCEL,
                                   TYPE_BARO, TYPE_TIME, TYPE_GYRO, TYPE_GPS};

    sensor_payload_record_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_record_valid (o_record_valid),
        .o_channel      (o_channel),
        .o_kind         (o_kind),
        .o_value_x      (o_value_x),
        .o_value_y      (o_value_y),
        .o_value_z      (o_value_z),
        .o_buffer_end   (o_buffer_end),
        .o_buffer_ok    (o_buffer_ok)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("sensor_payload_record_decoder regression: fail");
            $finish;
        end
    end

    // no gaps while the receiver is held off, so the record queue backs up
    function automatic int sender_gap();
        if (rx_holding) return 0;
        if ((bytes_sent / 64) % 3 == 0) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        do @(posedge i_clk); while (full);
        pred.take_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buf_q.size(); i++)
            send_byte(buf_q[i], i == buf_q.size() - 1, sender_gap());
    endtask

    task automatic add_record(output int len);
        int sel;
        sel = $urandom_range(0, 12);
        buf_q.push_back(8'($urandom_range(0, 255)));
        buf_q.push_back(type_codes[sel]);
        len = 2 + record_predictor::payload_len(4'(sel));
        repeat (len - 2) buf_q.push_back(payload_byte());
    endtask

    task automatic build_random_buffer();
        int         sel;
        int         len;
        logic [7:0] t;
        logic [3:0] k;
        buf_q.delete();
        sel = $urandom_range(0, 9);
        if (sel <= 6) repeat ($urandom_range(1, 4)) add_record(len);
        else if (sel <= 8) repeat ($urandom_range(0, 2)) add_record(len);
        if (sel == 7) begin
            buf_q.push_back(8'($urandom_range(0, 255)));
            do t = 8'($urandom_range(0, 255)); while (record_predictor::lookup_kind(t, k));
            buf_q.push_back(t);
            repeat ($urandom_range(0, 5)) buf_q.push_back(8'($urandom_range(0, 255)));
        end else if (sel == 8) begin
            // cut the record short: ends on channel, type or a payload byte
            add_record(len);
            repeat ($urandom_range(1, len - 1)) void'(buf_q.pop_back());
        end else if (sel == 9) begin
            repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain_results();
        int          stall;
        lpp_result_t got;
        forever begin
            if (!hold_done && results_seen >= 150) begin
                stall      = 400;
                hold_done  = 1'b1;
                rx_holding = 1'b1;
            end else if ((results_seen / 48) % 3 == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 13);
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rx_holding = 1'b0;
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got.record_valid = o_record_valid;
            got.channel      = o_channel;
            got.kind         = o_kind;
            got.value_x      = o_value_x;
            got.value_y      = o_value_y;
            got.value_z      = o_value_z;
            got.buffer_end   = o_buffer_end;
            got.buffer_ok    = o_buffer_ok;
            pred.check_record(got);
            results_seen++;
        end
    endtask

    initial begin
        bit paused;
        pred         = new();
        cycles       = 0;
        bytes_sent   = 0;
        results_seen = 0;
        rx_holding   = 1'b0;
        hold_done    = 1'b0;
        paused       = 1'b0;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        pop         <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none

        // gps with extreme coordinates, ends cleanly
        buf_q = '{8'hFF, TYPE_GPS, 8'h80, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF};
        send_buffer();
        // full-scale time value
        buf_q = '{8'h00, TYPE_TIME, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_buffer();
        // buffer of a lone channel byte
        buf_q = '{8'h5A};
        send_buffer();
        // unknown type, then a valid-looking record that must be ignored
        buf_q = '{8'h01, 8'hF0, TYPE_DIN, 8'h00};
        send_buffer();
        // ends on the type byte, then mid-payload
        buf_q = '{8'h02, TYPE_ACCEL};
        send_buffer();
        buf_q = '{8'h03, TYPE_AIN, 8'h80};
        send_buffer();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if (!paused && bytes_sent >= RANDOM_BYTES / 2) begin
                paused = 1'b1;
                push <= 1'b0;
                @(posedge i_clk);
                while (pred.pending() != 0) @(posedge i_clk);
            end
            build_random_buffer();
            send_buffer();
        end
        push <= 1'b0;

        while (pred.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pred.errors == 0) begin
            $display("sensor_payload_record_decoder regression: pass");
        end else begin
            $display("sensor_payload_record_decoder regression: fail");
        end
        $finish;
    end

endmodule
